// ===== src/dtcf_pkg.sv =====
// Package with constants and types shared by the double to custom float converter.
package dtcf_pkg;
	localparam int OUTPUT_WIDTH = 64;
	localparam int DBL_FRAC_BITS = 52;
	localparam logic [10:0] DBL_EXP_ONES = 11'h7FF;
	localparam logic [10:0] DBL_BIAS = 11'd1023;
	localparam logic [3:0] EXP_W_MIN = 4'd2;
	localparam logic [3:0] EXP_W_MAX = 4'd11;
	localparam logic [6:0] TOT_W_MIN = 7'd4;
	localparam logic [6:0] TOT_W_MAX = 7'(OUTPUT_WIDTH);
	localparam logic [3:0] EXP_W_RESET = 4'd8;
	localparam logic [6:0] TOT_W_RESET = 7'd32;
	localparam logic REG_EXP_W = 1'b0;
	localparam logic REG_TOT_W = 1'b1;

	typedef struct packed {
		logic [63:0] word;
		logic        ovf;
		logic        unf;
	} result_t;
endpackage

// ===== src/double_to_custom_float.sv =====
// Top level of the double to custom float converter.
// A word at a start edge goes to the input register, then to the result register.
// Throughput: one word per cycle; the input register and the result register form the
// only pipeline, and the conversion between them is a single pass of shifts and an add.
// Reset: arst_n clears the valid flags at once and loads the width registers with 8 and 32.
// The receiver cannot stall; each result is shown for exactly one cycle.
module double_to_custom_float import dtcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value_bits,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output logic        done,
	output logic [63:0] packed_word,
	output logic        overflow,
	output logic        underflow
);
	logic [3:0]  exp_w_q;
	logic [6:0]  tot_w_q;
	logic        vld_s1;
	logic [63:0] val_s1;
	logic        vld_s2;
	result_t     res_s2;
	result_t     res;

	logic [6:0]  t;
	logic [3:0]  e;
	logic [6:0]  f;
	logic [63:0] ones_exp;
	logic [63:0] sign_word;
	logic [10:0] dexp;
	logic [51:0] dfrac;
	logic [12:0] biased;
	logic [12:0] bias;
	logic [63:0] fr;
	logic [63:0] tmask;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_w_q <= EXP_W_RESET;
			tot_w_q <= TOT_W_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_EXP_W) exp_w_q <= cfg_data[3:0];
			else tot_w_q <= cfg_data;
		end
	end

	always_comb begin
		t = tot_w_q;
		if (t < TOT_W_MIN) t = TOT_W_MIN;
		if (t > TOT_W_MAX) t = TOT_W_MAX;
		e = exp_w_q;
		if (e < EXP_W_MIN) e = EXP_W_MIN;
		if (e > EXP_W_MAX) e = EXP_W_MAX;
		if ({3'd0, e} > t - 7'd1) e = 4'(t - 7'd1);
		f = t - {3'd0, e} - 7'd1;
		ones_exp = ~(64'hFFFF_FFFF_FFFF_FFFF << e);
		tmask = (t == 7'd64) ? 64'hFFFF_FFFF_FFFF_FFFF : ~(64'hFFFF_FFFF_FFFF_FFFF << t);
		sign_word = {63'd0, val_s1[63]} << (t - 7'd1);
		dexp = val_s1[62:52];
		dfrac = val_s1[51:0];
		bias = 13'(ones_exp[11:1]);
		biased = {2'd0, dexp} - {2'd0, DBL_BIAS} + bias;
		if (f <= 7'(DBL_FRAC_BITS)) fr = {12'd0, dfrac} >> (7'(DBL_FRAC_BITS) - f);
		else fr = {12'd0, dfrac} << (f - 7'(DBL_FRAC_BITS));
		res.ovf = 1'b0;
		res.unf = 1'b0;
		res.word = 64'd0;
		if (dexp == DBL_EXP_ONES) begin
			res.word = sign_word | (ones_exp << f);
			res.ovf = 1'b1;
		end else if (dexp == 11'd0) begin
			if (dfrac != 52'd0) begin
				res.word = sign_word;
				res.unf = 1'b1;
			end
		end else if (!biased[12] && biased >= ones_exp[12:0]) begin
			res.word = sign_word | (ones_exp << f);
			res.ovf = 1'b1;
		end else if (biased[12] || biased == 13'd0) begin
			res.word = sign_word;
			res.unf = 1'b1;
		end else begin
			res.word = sign_word | ({51'd0, biased} << f) | fr;
		end
		res.word = res.word & tmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) val_s1 <= value_bits;
		if (vld_s1) res_s2 <= res;
	end

	assign done = vld_s2;
	assign packed_word = res_s2.word;
	assign overflow = res_s2.ovf;
	assign underflow = res_s2.unf;
endmodule

// ===== src/dtcf_checker.sv =====
// Port checker for the double to custom float converter, bound to the top level.
module dtcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] packed_word,
	input logic        overflow,
	input logic        underflow
);
	// Every accepted word yields a result with done high.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2)) else $error("unexpected result");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(overflow && underflow)) else $error("both flags set");
	a_zero_unf: assert property (@(posedge clk) disable iff (!arst_n)
		done && packed_word == 64'd0 |-> !overflow) else $error("overflow on zero word");
endmodule

bind double_to_custom_float dtcf_checker u_dtcf_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.packed_word(packed_word), .overflow(overflow), .underflow(underflow)
);
